// ----- rtl/dlcc_pkg.sv -----
// Shared types and constants for the dual line call controller.
// No dependencies.
package dlcc_pkg;

   localparam int LINES_DEF       = 2;
   localparam int QUEUE_DEPTH_DEF = 8;
   localparam int TIMER_W         = 10;
   localparam int LINE_W          = 8;

   localparam logic [TIMER_W-1:0] RING_ON_RST   = 10'd80;
   localparam logic [TIMER_W-1:0] RING_OFF_RST  = 10'd160;
   localparam logic [TIMER_W-1:0] HANGUP_RST    = 10'd20;

   typedef enum logic [2:0] {
      ACT_TICK  = 3'd0,
      ACT_POP   = 3'd1,
      ACT_OR    = 3'd2,
      ACT_INCALL= 3'd3,
      ACT_RING  = 3'd4,
      ACT_END   = 3'd5,
      ACT_POWER = 3'd6,
      ACT_NOP   = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_WANT_OR  = 3'd1,
      EV_ANSWER   = 3'd2,
      EV_HANG_UP  = 3'd3,
      EV_RING_REQ = 3'd4,
      EV_BUSY     = 3'd5
   } event_type;

   typedef enum logic [1:0] {
      LED_ON_HOOK  = 2'd0,
      LED_OFF_HOOK = 2'd1,
      LED_RINGING  = 2'd2
   } led_mode_type;

   typedef enum logic [2:0] {
      RP_OFF    = 3'd0,
      RP_START  = 3'd1,
      RP_BURST  = 3'd2,
      RP_PAUSE  = 3'd3,
      RP_PICKUP = 3'd4,
      RP_STOP   = 3'd5
   } ring_phase_type;

   typedef enum logic [3:0] {
      CP_IDLE     = 4'd0,
      CP_WANT_OR  = 4'd1,
      CP_OR_WAIT  = 4'd2,
      CP_OR_CONN  = 4'd3,
      CP_RINGING  = 4'd4,
      CP_IN_CALL  = 4'd5,
      CP_ON_HOOK  = 4'd6,
      CP_DISCONN  = 4'd7,
      CP_HANG_SUB = 4'd8
   } call_phase_type;

   localparam logic [1:0] REG_RING_ON  = 2'd0;
   localparam logic [1:0] REG_RING_OFF = 2'd1;
   localparam logic [1:0] REG_HANGUP   = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic load;    // capture request
      logic tick;    // run per-line tick
      logic host;    // run host command / pop
      logic publish; // latch result
   } dp_cmd_type;

endpackage

// ----- rtl/dual_line_call_controller.sv -----
// Top level of the dual line call controller: register port, sequencer, datapath.
// Depends on dlcc_pkg, dlcc_ctrl, dlcc_datapath.
//
// Each request is first captured; then the datapath runs either the per-line tick
// (hook, LED, ring cadence and call machine for all lines) or the host command;
// then the result register is loaded. The sequencer handles one request at a
// time and takes a new one only once the previous result has left or is leaving.
module dual_line_call_controller
   import dlcc_pkg::*;
#(
   parameter int LINES       = LINES_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_action,
   input  logic [LINE_W-1:0] req_line,
   input  logic [LINES-1:0]  req_hook_bits,
   input  logic              req_power_on,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_event_code,
   output logic [LINE_W-1:0] rsp_event_line,
   output logic [LINES-1:0]  rsp_busy_bits,
   output logic              rsp_attention,
   output logic [LINES-1:0]  rsp_ring_mode_bits,
   output logic [LINES-1:0]  rsp_reverse_polarity_bits,
   output logic [LINES-1:0]  rsp_mute_bits,
   output logic [LINES-1:0]  rsp_led_lit_bits,
   output logic [LINES-1:0]  rsp_powered_bits,
   output logic              rsp_overflow,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic [TIMER_W-1:0] ring_on_ff, ring_off_ff, hangup_ff;
   logic [1:0]         reg_idx;
   dp_cmd_type         cmd;
   logic               is_tick;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_on_ff  <= RING_ON_RST;
         ring_off_ff <= RING_OFF_RST;
         hangup_ff   <= HANGUP_RST;
      end else if (psel && penable && pwrite) begin
         unique case (reg_idx)
            REG_RING_ON:  ring_on_ff  <= pwdata[TIMER_W-1:0];
            REG_RING_OFF: ring_off_ff <= pwdata[TIMER_W-1:0];
            REG_HANGUP:   hangup_ff   <= pwdata[TIMER_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_RING_ON:  prdata = {22'd0, ring_on_ff};
         REG_RING_OFF: prdata = {22'd0, ring_off_ff};
         REG_HANGUP:   prdata = {22'd0, hangup_ff};
         default:      prdata = '0;
      endcase
   end

   dlcc_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .is_tick, .cmd
   );

   dlcc_datapath #(.LINES(LINES), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
      .clock, .reset, .cmd, .req_action, .req_line, .req_hook_bits, .req_power_on,
      .ring_on(ring_on_ff), .ring_off(ring_off_ff), .hangup_wait(hangup_ff),
      .is_tick, .rsp_event_code, .rsp_event_line, .rsp_busy_bits, .rsp_attention,
      .rsp_ring_mode_bits, .rsp_reverse_polarity_bits, .rsp_mute_bits,
      .rsp_led_lit_bits, .rsp_powered_bits, .rsp_overflow
   );

endmodule

// ----- rtl/dlcc_ctrl.sv -----
// Sequencer for the dual line call controller: load, execute, publish, hold.
// Depends on dlcc_pkg.
module dlcc_ctrl
   import dlcc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       is_tick,
   output dp_cmd_type cmd
);

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_PUB} state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   // a new request is taken once the previous result has left or is leaving
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd         = '0;
      cmd.load    = req_valid && req_ready;
      cmd.tick    = (state_ff == S_EXEC) && is_tick;
      cmd.host    = (state_ff == S_EXEC) && !is_tick;
      cmd.publish = (state_ff == S_PUB);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (cmd.load) state_ff <= S_EXEC;
            S_EXEC: state_ff <= S_PUB;
            S_PUB: begin
               state_ff     <= S_IDLE;
               rsp_valid_ff <= 1'b1;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ----- rtl/dlcc_datapath.sv -----
// Per-line state, ring cadence, call machine and event queue.
// Depends on dlcc_pkg.
module dlcc_datapath
   import dlcc_pkg::*;
#(
   parameter int LINES       = LINES_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   input  logic [2:0]         req_action,
   input  logic [LINE_W-1:0]  req_line,
   input  logic [LINES-1:0]   req_hook_bits,
   input  logic               req_power_on,
   input  logic [TIMER_W-1:0] ring_on,
   input  logic [TIMER_W-1:0] ring_off,
   input  logic [TIMER_W-1:0] hangup_wait,
   output logic               is_tick,
   output logic [2:0]         rsp_event_code,
   output logic [LINE_W-1:0]  rsp_event_line,
   output logic [LINES-1:0]   rsp_busy_bits,
   output logic               rsp_attention,
   output logic [LINES-1:0]   rsp_ring_mode_bits,
   output logic [LINES-1:0]   rsp_reverse_polarity_bits,
   output logic [LINES-1:0]   rsp_mute_bits,
   output logic [LINES-1:0]   rsp_led_lit_bits,
   output logic [LINES-1:0]   rsp_powered_bits,
   output logic               rsp_overflow
);

   localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW  = $clog2(QUEUE_DEPTH + 1);
   localparam int LW  = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int EW  = 3 + LW;

   // captured request
   logic [2:0]        act_ff;
   logic [LINE_W-1:0] line_ff;
   logic [LINES-1:0]  hookin_ff;
   logic              pwr_ff;

   logic [LINES-1:0] hook_now_ff;
   led_mode_type     led_ff   [LINES];
   ring_phase_type   rp_ff    [LINES];
   call_phase_type   cp_ff    [LINES];
   call_phase_type   resume_ff[LINES];
   logic [TIMER_W-1:0] rcnt_ff[LINES];
   logic [TIMER_W-1:0] hcnt_ff[LINES];
   logic [LINES-1:0] adv_ff, ring_ff, rev_ff, mute_ff, lit_ff, pwr_bits_ff;

   logic [EW-1:0]    mem [QUEUE_DEPTH];
   logic [QW-1:0]    head_ff, tail_ff;
   logic [CW-1:0]    count_ff;
   logic             drop_ff;

   logic [2:0]        code_ff;
   logic [LINE_W-1:0] evline_ff;

   // result registers
   logic [2:0]        o_code_ff;
   logic [LINE_W-1:0] o_line_ff;
   logic [LINES-1:0]  o_busy_ff, o_ring_ff, o_rev_ff, o_mute_ff, o_lit_ff, o_pwr_ff;
   logic              o_att_ff, o_ovf_ff;

   assign is_tick = (act_ff == ACT_TICK);

   // combinational tick evaluation, lines in order since they share the queue
   logic [LINES-1:0] led_pin;
   led_mode_type     led_n  [LINES];
   ring_phase_type   rp_n   [LINES];
   call_phase_type   cp_n   [LINES];
   call_phase_type   res_n  [LINES];
   logic [TIMER_W-1:0] rc_n [LINES];
   logic [TIMER_W-1:0] hc_n [LINES];
   logic [LINES-1:0] adv_n, ring_n, rev_n, mute_n;
   logic [LINES-1:0] push_v;
   event_type        push_c [LINES];

   always_comb begin
      logic now_o, was_o, went_on;
      for (int i = 0; i < LINES; i++) begin
         now_o = hookin_ff[i];
         was_o = hook_now_ff[i];
         went_on = !now_o && was_o;
         led_n[i] = led_ff[i];
         if (now_o != was_o) led_n[i] = now_o ? LED_OFF_HOOK : LED_ON_HOOK;
         if (led_n[i] == LED_OFF_HOOK)      led_pin[i] = 1'b1;
         else if (led_n[i] == LED_RINGING)  led_pin[i] = !lit_ff[i];
         else                               led_pin[i] = 1'b0;
         rp_n[i] = rp_ff[i];
         rc_n[i] = rcnt_ff[i];
         ring_n[i] = ring_ff[i];
         rev_n[i] = rev_ff[i];
         mute_n[i] = mute_ff[i];
         case (rp_ff[i])
            RP_START: begin
               mute_n[i] = 1'b1;
               ring_n[i] = 1'b1;
               led_n[i]  = LED_RINGING;
               rc_n[i]   = ring_on;
               rp_n[i]   = RP_BURST;
            end
            RP_BURST, RP_PAUSE: begin
               if (now_o) begin
                  led_n[i] = LED_OFF_HOOK;
                  ring_n[i] = 1'b0;
                  rev_n[i] = 1'b0;
                  mute_n[i] = 1'b0;
                  rp_n[i] = RP_PICKUP;
               end else if (rcnt_ff[i] == '0) begin
                  if (rp_ff[i] == RP_PAUSE) begin
                     led_n[i] = LED_RINGING;
                     rc_n[i] = ring_on;
                     rp_n[i] = RP_BURST;
                  end else begin
                     rev_n[i] = 1'b0;
                     led_n[i] = LED_ON_HOOK;
                     rc_n[i] = ring_off;
                     rp_n[i] = RP_PAUSE;
                  end
               end else begin
                  if (rp_ff[i] == RP_BURST) rev_n[i] = !rev_ff[i];
                  rc_n[i] = rcnt_ff[i] - 1'b1;
               end
            end
            RP_STOP: begin
               ring_n[i] = 1'b0;
               rev_n[i] = 1'b0;
               mute_n[i] = 1'b0;
               led_n[i] = LED_ON_HOOK;
               rp_n[i] = RP_OFF;
            end
            default: ;
         endcase
         cp_n[i] = cp_ff[i];
         res_n[i] = resume_ff[i];
         hc_n[i] = hcnt_ff[i];
         adv_n[i] = adv_ff[i];
         push_v[i] = 1'b0;
         push_c[i] = EV_NONE;
         case (cp_ff[i])
            CP_WANT_OR: begin
               if (went_on) cp_n[i] = CP_IDLE;
               else begin
                  push_v[i] = 1'b1;
                  push_c[i] = EV_WANT_OR;
                  adv_n[i] = 1'b0;
                  cp_n[i] = CP_OR_WAIT;
               end
            end
            CP_OR_WAIT, CP_OR_CONN: begin
               if (went_on) begin
                  hc_n[i] = hangup_wait;
                  res_n[i] = cp_ff[i];
                  cp_n[i] = CP_HANG_SUB;
               end else if (adv_ff[i]) begin
                  adv_n[i] = 1'b0;
                  cp_n[i] = (cp_ff[i] == CP_OR_WAIT) ? CP_OR_CONN : CP_IN_CALL;
               end
            end
            CP_RINGING: begin
               if (rp_n[i] == RP_PICKUP) begin
                  push_v[i] = 1'b1;
                  push_c[i] = EV_ANSWER;
                  rp_n[i] = RP_OFF;
                  cp_n[i] = CP_IN_CALL;
               end else if (adv_ff[i]) begin
                  rp_n[i] = RP_STOP;
                  adv_n[i] = 1'b0;
                  cp_n[i] = CP_DISCONN;
               end
            end
            CP_IN_CALL: begin
               if (went_on) begin
                  hc_n[i] = hangup_wait;
                  res_n[i] = cp_ff[i];
                  cp_n[i] = CP_HANG_SUB;
               end else if (adv_ff[i]) begin
                  adv_n[i] = 1'b0;
                  cp_n[i] = CP_DISCONN;
               end
            end
            CP_ON_HOOK: begin
               push_v[i] = 1'b1;
               push_c[i] = EV_HANG_UP;
               res_n[i] = CP_IDLE;
               adv_n[i] = 1'b0;
               cp_n[i] = CP_IDLE;
            end
            CP_DISCONN: begin
               if (!now_o) begin
                  adv_n[i] = 1'b0;
                  cp_n[i] = CP_IDLE;
               end
            end
            CP_HANG_SUB: begin
               if (hcnt_ff[i] == '0) cp_n[i] = CP_ON_HOOK;
               else begin
                  if (now_o) cp_n[i] = resume_ff[i];
                  hc_n[i] = hcnt_ff[i] - 1'b1;
               end
            end
            default: begin
               cp_n[i] = CP_IDLE;
               if (now_o && !was_o) cp_n[i] = CP_WANT_OR;
               if (adv_ff[i]) begin
                  adv_n[i] = 1'b0;
                  rp_n[i] = RP_START;
                  cp_n[i] = CP_RINGING;
               end
            end
         endcase
      end
   end

   // host command decode
   logic            line_ok;
   logic [LW-1:0]   hl;
   logic            h_push;
   event_type       h_code;
   logic            h_adv;
   assign line_ok = ({24'd0, line_ff} < LINES);
   assign hl      = line_ff[LW-1:0];

   always_comb begin
      h_push = 1'b0;
      h_code = EV_NONE;
      h_adv  = 1'b0;
      if (line_ok) begin
         case (act_ff)
            ACT_OR:     h_adv = (cp_ff[hl] == CP_OR_WAIT);
            ACT_INCALL: h_adv = (cp_ff[hl] == CP_OR_CONN);
            ACT_RING: begin
               h_push = 1'b1;
               if (cp_ff[hl] == CP_IDLE) begin
                  h_adv = 1'b1;
                  h_code = EV_RING_REQ;
               end else h_code = EV_BUSY;
            end
            ACT_END: h_adv = (cp_ff[hl] == CP_RINGING) || (cp_ff[hl] == CP_IN_CALL);
            default: ;
         endcase
      end
   end

   // queue push, at most one per line in a tick; a pop only moves the count down
   logic [QW-1:0] head_n;
   logic [CW-1:0] count_n;
   logic          drop_n;
   logic [QUEUE_DEPTH-1:0] wr_en;
   logic [EW-1:0] wr_data [QUEUE_DEPTH];

   function automatic logic [QW-1:0] qinc(input logic [QW-1:0] p);
      if ({{(32-QW){1'b0}}, p} == QUEUE_DEPTH - 1) return '0;
      return p + 1'b1;
   endfunction

   always_comb begin
      head_n  = head_ff;
      count_n = count_ff;
      drop_n  = drop_ff;
      wr_en   = '0;
      for (int k = 0; k < QUEUE_DEPTH; k++) wr_data[k] = '0;
      if (cmd.tick) begin
         for (int i = 0; i < LINES; i++) begin
            if (push_v[i]) begin
               if ({{(32-CW){1'b0}}, count_n} >= QUEUE_DEPTH) drop_n = 1'b1;
               else begin
                  wr_en[head_n]   = 1'b1;
                  wr_data[head_n] = {push_c[i], LW'(i)};
                  head_n  = qinc(head_n);
                  count_n = count_n + 1'b1;
               end
            end
         end
      end else if (cmd.host && h_push) begin
         if ({{(32-CW){1'b0}}, count_n} >= QUEUE_DEPTH) drop_n = 1'b1;
         else begin
            wr_en[head_n]   = 1'b1;
            wr_data[head_n] = {h_code, hl};
            head_n  = qinc(head_n);
            count_n = count_n + 1'b1;
         end
      end else if (cmd.host && act_ff == ACT_POP && count_ff != '0) begin
         count_n = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QUEUE_DEPTH; k++)
         if (wr_en[k]) mem[k] <= wr_data[k];
      if (cmd.load) begin
         act_ff    <= req_action;
         line_ff   <= req_line;
         hookin_ff <= req_hook_bits;
         pwr_ff    <= req_power_on;
      end
      // pop read is registered from the memory
      if (cmd.host && act_ff == ACT_POP && count_ff != '0) begin
         code_ff   <= mem[tail_ff][EW-1:LW];
         evline_ff <= LINE_W'(mem[tail_ff][LW-1:0]);
      end else if (cmd.host || cmd.tick) begin
         code_ff   <= EV_NONE;
         evline_ff <= '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hook_now_ff <= '0;
         adv_ff <= '0; ring_ff <= '0; rev_ff <= '0; mute_ff <= '0;
         lit_ff <= '0; pwr_bits_ff <= '0;
         head_ff <= '0; tail_ff <= '0; count_ff <= '0; drop_ff <= 1'b0;
         for (int i = 0; i < LINES; i++) begin
            led_ff[i] <= LED_ON_HOOK;
            rp_ff[i] <= RP_OFF;
            cp_ff[i] <= CP_IDLE;
            resume_ff[i] <= CP_IDLE;
            rcnt_ff[i] <= '0;
            hcnt_ff[i] <= '0;
         end
      end else begin
         if (cmd.tick) begin
            hook_now_ff  <= hookin_ff;
            lit_ff <= led_pin;
            ring_ff <= ring_n; rev_ff <= rev_n; mute_ff <= mute_n; adv_ff <= adv_n;
            for (int i = 0; i < LINES; i++) begin
               led_ff[i] <= led_n[i];
               rp_ff[i] <= rp_n[i];
               cp_ff[i] <= cp_n[i];
               resume_ff[i] <= res_n[i];
               rcnt_ff[i] <= rc_n[i];
               hcnt_ff[i] <= hc_n[i];
            end
         end
         if (cmd.tick || cmd.host) begin
            head_ff <= head_n;
            count_ff <= count_n;
            drop_ff <= drop_n;
         end
         if (cmd.host) begin
            if (act_ff == ACT_POP && count_ff != '0) tail_ff <= qinc(tail_ff);
            if (h_adv) adv_ff[hl] <= 1'b1;
            if (line_ok && act_ff == ACT_POWER) pwr_bits_ff[hl] <= pwr_ff;
         end
         // overflow is reported once then cleared
         if (cmd.publish) drop_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         o_code_ff <= code_ff;
         o_line_ff <= evline_ff;
         for (int i = 0; i < LINES; i++) o_busy_ff[i] <= (cp_ff[i] != CP_IDLE);
         o_att_ff  <= (count_ff != '0);
         o_ring_ff <= ring_ff;
         o_rev_ff  <= rev_ff;
         o_mute_ff <= mute_ff;
         o_lit_ff  <= lit_ff;
         o_pwr_ff  <= pwr_bits_ff;
         o_ovf_ff  <= drop_ff;
      end
   end

   assign rsp_event_code            = o_code_ff;
   assign rsp_event_line            = o_line_ff;
   assign rsp_busy_bits             = o_busy_ff;
   assign rsp_attention             = o_att_ff;
   assign rsp_ring_mode_bits        = o_ring_ff;
   assign rsp_reverse_polarity_bits = o_rev_ff;
   assign rsp_mute_bits             = o_mute_ff;
   assign rsp_led_lit_bits          = o_lit_ff;
   assign rsp_powered_bits          = o_pwr_ff;
   assign rsp_overflow              = o_ovf_ff;

endmodule

// ----- rtl/dlcc_checker.sv -----
// Port-level checks for the dual line call controller, bound to the top level.
// Depends on dlcc_pkg.
module dlcc_checker
   import dlcc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_event_code,
   input logic [7:0] rsp_event_line
);

   // an accepted request is answered once the sequencer has passed its execute and publish states
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##3 rsp_valid) else $error("result late");

   // no request taken while the previous one is being worked on
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("overlap");

   // a result without an event carries the no-event line marker
   a_event_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_code == EV_NONE |-> rsp_event_line == 8'd255)
      else $error("bad empty event");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_code))
      else $error("result dropped");

endmodule

bind dual_line_call_controller dlcc_checker u_chk (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_event_code, .rsp_event_line
);

// ----- tb/dual_line_call_controller_tb.sv -----
// Self-checking bench for dual_line_call_controller: directed table, then random traffic.
// Depends on dlcc_pkg and the controller RTL; line-card behaviour is predicted in-bench.
module dual_line_call_controller_tb;
   import dlcc_pkg::*;

   localparam int NLINES   = 2;
   localparam int QDEPTH   = 8;
   localparam int PIN_RING = 0;
   localparam int PIN_REV  = 1;
   localparam int PIN_MUTE = 2;
   localparam int PIN_LED  = 3;
   localparam int PIN_PWR  = 4;
   localparam int STALL_LIMIT = 3000;

   typedef struct packed {
      logic [2:0] code;
      logic [7:0] ev_line;
      logic [1:0] busy;
      logic       attn;
      logic [1:0] ring;
      logic [1:0] rev;
      logic [1:0] mute;
      logic [1:0] led;
      logic [1:0] pwr;
      logic       ovf;
   } line_status_type;

   typedef struct {
      logic [2:0]      act;
      logic [7:0]      ln;
      logic [1:0]      hook;
      logic            pon;
      bit              fixed;
      line_status_type want;
   } call_row_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_ready, req_power_on = 0;
   logic [2:0] req_action = ACT_NOP;
   logic [7:0] req_line = 0;
   logic [1:0] req_hook_bits = 0;
   logic rsp_valid, rsp_ready = 0, rsp_attention, rsp_overflow;
   logic [2:0] rsp_event_code;
   logic [7:0] rsp_event_line;
   logic [1:0] rsp_busy_bits, rsp_ring_mode_bits, rsp_reverse_polarity_bits;
   logic [1:0] rsp_mute_bits, rsp_led_lit_bits, rsp_powered_bits;
   logic psel = 0, penable = 0, pwrite = 0, pready;
   logic [3:0] paddr = 0;
   logic [31:0] pwdata = 0, prdata;

   dual_line_call_controller DUT (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // predicted line-card state
   logic [9:0] on_frames, off_frames, hang_frames;
   logic [1:0] hook_now, hook_prev;
   led_mode_type   led_md [NLINES];
   ring_phase_type rphase [NLINES];
   call_phase_type cphase [NLINES], resume [NLINES];
   logic [9:0] ring_cnt [NLINES], hang_cnt [NLINES];
   logic       adv [NLINES];
   logic [4:0] pins [NLINES];
   logic [2:0] ev_code [QDEPTH];
   logic [7:0] ev_ln [QDEPTH];
   logic [2:0] qhead, qtail;
   int         qcount;
   logic       dropped;

   line_status_type status_q [$];
   int mismatches = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   logic [1:0] hook_plan = 0;

   function automatic void push_event(int i, event_type c);
      if (qcount >= QDEPTH) begin
         dropped = 1;
      end else begin
         ev_code[qhead] = c;
         ev_ln[qhead] = 8'(i);
         qhead = qhead + 3'd1;
         qcount++;
      end
   endfunction

   function automatic void start_hangup(int i);
      hang_cnt[i] = hang_frames;
      resume[i] = cphase[i];
      cphase[i] = CP_HANG_SUB;
   endfunction

   function automatic void ring_cadence(int i);
      case (rphase[i])
         RP_START: begin
            pins[i][PIN_MUTE] = 1;
            pins[i][PIN_RING] = 1;
            led_md[i] = LED_RINGING;
            ring_cnt[i] = on_frames;
            rphase[i] = RP_BURST;
         end
         RP_BURST, RP_PAUSE: begin
            if (hook_now[i]) begin
               // ring trip, in burst or pause
               led_md[i] = LED_OFF_HOOK;
               pins[i][PIN_RING] = 0;
               pins[i][PIN_REV] = 0;
               pins[i][PIN_MUTE] = 0;
               rphase[i] = RP_PICKUP;
            end else if (ring_cnt[i] == 0) begin
               if (rphase[i] == RP_PAUSE) begin
                  led_md[i] = LED_RINGING;
                  ring_cnt[i] = on_frames;
                  rphase[i] = RP_BURST;
               end else begin
                  pins[i][PIN_REV] = 0;
                  led_md[i] = LED_ON_HOOK;
                  ring_cnt[i] = off_frames;
                  rphase[i] = RP_PAUSE;
               end
            end else begin
               if (rphase[i] == RP_BURST) pins[i][PIN_REV] = !pins[i][PIN_REV];
               ring_cnt[i]--;
            end
         end
         RP_STOP: begin
            pins[i][PIN_RING] = 0;
            pins[i][PIN_REV] = 0;
            pins[i][PIN_MUTE] = 0;
            led_md[i] = LED_ON_HOOK;
            rphase[i] = RP_OFF;
         end
         default: ;
      endcase
   endfunction

   function automatic void call_machine(int i);
      logic went_on;
      went_on = !hook_now[i] && hook_prev[i];
      case (cphase[i])
         CP_WANT_OR: begin
            if (went_on) cphase[i] = CP_IDLE;
            else begin
               push_event(i, EV_WANT_OR);
               adv[i] = 0;
               cphase[i] = CP_OR_WAIT;
            end
         end
         CP_OR_WAIT, CP_OR_CONN: begin
            if (went_on) start_hangup(i);
            else if (adv[i]) begin
               adv[i] = 0;
               cphase[i] = (cphase[i] == CP_OR_WAIT) ? CP_OR_CONN : CP_IN_CALL;
            end
         end
         CP_RINGING: begin
            if (rphase[i] == RP_PICKUP) begin
               push_event(i, EV_ANSWER);
               rphase[i] = RP_OFF;
               cphase[i] = CP_IN_CALL;
            end else if (adv[i]) begin
               rphase[i] = RP_STOP;
               adv[i] = 0;
               cphase[i] = CP_DISCONN;
            end
         end
         CP_IN_CALL: begin
            if (went_on) start_hangup(i);
            else if (adv[i]) begin
               adv[i] = 0;
               cphase[i] = CP_DISCONN;
            end
         end
         CP_ON_HOOK: begin
            push_event(i, EV_HANG_UP);
            resume[i] = CP_IDLE;
            adv[i] = 0;
            cphase[i] = CP_IDLE;
         end
         CP_DISCONN: begin
            if (!hook_now[i]) begin
               adv[i] = 0;
               cphase[i] = CP_IDLE;
            end
         end
         CP_HANG_SUB: begin
            if (hang_cnt[i] == 0) cphase[i] = CP_ON_HOOK;
            else begin
               if (hook_now[i]) cphase[i] = resume[i];
               hang_cnt[i]--;
            end
         end
         default: begin
            cphase[i] = CP_IDLE;
            if (hook_now[i] && !hook_prev[i]) cphase[i] = CP_WANT_OR;
            if (adv[i]) begin
               adv[i] = 0;
               rphase[i] = RP_START;
               cphase[i] = CP_RINGING;
            end
         end
      endcase
   endfunction

   function automatic line_status_type line_card_step(logic [2:0] act, logic [7:0] ln,
                                                      logic [1:0] hook, logic pon);
      line_status_type r;
      r = '0;
      r.code = EV_NONE;
      r.ev_line = 8'd255;
      if (act == ACT_TICK) begin
         hook_prev = hook_now;
         hook_now = hook;
         for (int i = 0; i < NLINES; i++)
            if (hook_now[i] != hook_prev[i])
               led_md[i] = hook_now[i] ? LED_OFF_HOOK : LED_ON_HOOK;
         for (int i = 0; i < NLINES; i++) begin
            if (led_md[i] == LED_OFF_HOOK) pins[i][PIN_LED] = 1;
            else if (led_md[i] == LED_RINGING) pins[i][PIN_LED] = !pins[i][PIN_LED];
            else pins[i][PIN_LED] = 0;
         end
         for (int i = 0; i < NLINES; i++) ring_cadence(i);
         for (int i = 0; i < NLINES; i++) call_machine(i);
      end else if (act == ACT_POP) begin
         if (qcount > 0) begin
            r.code = ev_code[qtail];
            r.ev_line = ev_ln[qtail];
            qtail = qtail + 3'd1;
            qcount--;
         end
      end else if (act != ACT_NOP && ln < NLINES) begin
         case (act)
            ACT_OR:     if (cphase[ln] == CP_OR_WAIT) adv[ln] = 1;
            ACT_INCALL: if (cphase[ln] == CP_OR_CONN) adv[ln] = 1;
            ACT_RING: begin
               if (cphase[ln] == CP_IDLE) begin
                  adv[ln] = 1;
                  push_event(ln, EV_RING_REQ);
               end else push_event(ln, EV_BUSY);
            end
            ACT_END:
               if (cphase[ln] == CP_RINGING || cphase[ln] == CP_IN_CALL) adv[ln] = 1;
            default: pins[ln][PIN_PWR] = pon;
         endcase
      end
      for (int i = 0; i < NLINES; i++) begin
         r.busy[i] = cphase[i] != CP_IDLE;
         r.ring[i] = pins[i][PIN_RING];
         r.rev[i]  = pins[i][PIN_REV];
         r.mute[i] = pins[i][PIN_MUTE];
         r.led[i]  = pins[i][PIN_LED];
         r.pwr[i]  = pins[i][PIN_PWR];
      end
      r.attn = qcount > 0;
      r.ovf = dropped;
      dropped = 0;
      return r;
   endfunction

   // caller sits just after a rising edge
   task automatic send_request(logic [2:0] act, logic [7:0] ln, logic [1:0] hook,
                               logic pon, bit fixed, line_status_type want);
      line_status_type r;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         if (gap > 0) begin
            req_valid <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1;
      req_action <= act;
      req_line <= ln;
      req_hook_bits <= hook;
      req_power_on <= pon;
      do @(posedge clock); while (!req_ready);
      r = line_card_step(act, ln, hook, pon);
      status_q.push_back(fixed ? want : r);
   endtask

   task automatic write_timer(logic [1:0] idx, logic [9:0] val);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= {idx, 2'b00};
      pwdata <= {22'd0, val};
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      case (idx)
         REG_RING_ON:  on_frames = val;
         REG_RING_OFF: off_frames = val;
         default:      hang_frames = val;
      endcase
   endtask

   task automatic set_timers(logic [9:0] ron, logic [9:0] roff, logic [9:0] hang);
      req_valid <= 0;
      while (status_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      write_timer(REG_RING_ON, ron);
      write_timer(REG_RING_OFF, roff);
      write_timer(REG_HANGUP, hang);
   endtask

   task automatic random_request();
      logic [2:0] act;
      logic [7:0] ln;
      int pick;
      pick = $urandom_range(0, 99);
      ln = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 1));
      for (int i = 0; i < NLINES; i++)
         if ($urandom_range(0, 6) == 0) hook_plan[i] = !hook_plan[i];
      if (pick < 45) act = ACT_TICK;
      else if (pick < 60) act = ACT_POP;
      else if (pick < 95) begin
         act = 3'($urandom_range(ACT_OR, ACT_POWER));
         if (ln < NLINES && $urandom_range(0, 9) < 7) begin
            if (cphase[ln] == CP_OR_WAIT) act = ACT_OR;
            else if (cphase[ln] == CP_OR_CONN) act = ACT_INCALL;
         end
      end else act = ACT_NOP;
      // hook bits only matter on a tick, noise elsewhere
      send_request(act, ln, (act == ACT_TICK) ? hook_plan : 2'($urandom), 1'($urandom),
                   1'b0, '0);
   endtask

   // receiver stall pattern: free-flowing, random, then sparse
   int rx_cycle = 0;
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      case ((rx_cycle / 150) % 3)
         0: rsp_ready <= 1;
         1: rsp_ready <= $urandom_range(0, 1);
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(posedge clock) begin
      line_status_type got;
      got = {rsp_event_code, rsp_event_line, rsp_busy_bits, rsp_attention,
             rsp_ring_mode_bits, rsp_reverse_polarity_bits, rsp_mute_bits,
             rsp_led_lit_bits, rsp_powered_bits, rsp_overflow};
      if (!reset && rsp_valid && rsp_ready) begin
         if (status_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
         end else begin
            if (got !== status_q[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p got %p", status_q[0], got);
            end
            void'(status_q.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("dual_line_call_controller_tb failed");
         $finish;
      end
   end

   call_row_type directed [$];
   line_status_type quiet;

   initial begin
      on_frames = RING_ON_RST;
      off_frames = RING_OFF_RST;
      hang_frames = HANGUP_RST;
      hook_now = 0;
      hook_prev = 0;
      for (int i = 0; i < NLINES; i++) begin
         led_md[i] = LED_ON_HOOK;
         rphase[i] = RP_OFF;
         cphase[i] = CP_IDLE;
         resume[i] = CP_IDLE;
         ring_cnt[i] = 0;
         hang_cnt[i] = 0;
         adv[i] = 0;
         pins[i] = 0;
      end
      qhead = 0;
      qtail = 0;
      qcount = 0;
      dropped = 0;

      quiet = '0;
      quiet.code = EV_NONE;
      quiet.ev_line = 8'd255;
      directed.push_back('{ACT_POP,    0,   0, 0, 1, quiet});
      directed.push_back('{ACT_NOP,    255, 3, 1, 1, quiet});
      quiet.pwr = 2'b01;
      directed.push_back('{ACT_POWER,  0,   0, 1, 1, quiet});
      quiet.pwr = 2'b11;
      directed.push_back('{ACT_POWER,  1,   0, 1, 1, quiet});
      directed.push_back('{ACT_POWER,  200, 0, 0, 1, quiet});
      directed.push_back('{ACT_RING,   2,   0, 0, 1, quiet});
      quiet.busy = 2'b11;
      quiet.led = 2'b11;
      directed.push_back('{ACT_TICK,   0,   3, 0, 1, quiet});
      directed.push_back('{ACT_TICK,   0,   3, 0, 0, quiet});
      directed.push_back('{ACT_OR,     0,   0, 0, 0, quiet});
      directed.push_back('{ACT_TICK,   0,   3, 0, 0, quiet});
      directed.push_back('{ACT_INCALL, 0,   0, 0, 0, quiet});
      directed.push_back('{ACT_TICK,   0,   3, 0, 0, quiet});
      directed.push_back('{ACT_END,    0,   0, 0, 0, quiet});
      directed.push_back('{ACT_TICK,   0,   3, 0, 0, quiet});
      directed.push_back('{ACT_TICK,   0,   0, 0, 0, quiet});
      directed.push_back('{ACT_POP,    0,   0, 0, 0, quiet});
      directed.push_back('{ACT_POP,    0,   0, 0, 0, quiet});
      directed.push_back('{ACT_RING,   0,   0, 0, 0, quiet});
      directed.push_back('{ACT_RING,   1,   0, 0, 0, quiet});
      directed.push_back('{ACT_TICK,   0,   0, 0, 0, quiet});
      directed.push_back('{ACT_TICK,   0,   0, 0, 0, quiet});
      directed.push_back('{ACT_TICK,   0,   1, 0, 0, quiet});
      directed.push_back('{ACT_TICK,   0,   1, 0, 0, quiet});
      directed.push_back('{ACT_POWER,  1,   0, 0, 0, quiet});
      directed.push_back('{ACT_POP,    0,   0, 0, 0, quiet});

      repeat (2) @(posedge clock);
      reset <= 0;
      foreach (directed[k])
         send_request(directed[k].act, directed[k].ln, directed[k].hook,
                      directed[k].pon, directed[k].fixed, directed[k].want);

      // timer settings: the zero and one extremes, small mixed values, the maximum, then small values again
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: set_timers(10'd0, 10'd0, 10'd0);
            1: set_timers(10'd1, 10'd1, 10'd1);
            2: set_timers(10'd3, 10'd5, 10'd2);
            3: set_timers(10'd1023, 10'd1023, 10'd1023);
            default: set_timers(10'd2, 10'd4, 10'd6);
         endcase
         repeat (phase == 3 ? 60 : 210) random_request();
      end

      req_valid <= 0;
      while (status_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && status_q.size() == 0) $display("dual_line_call_controller_tb passed");
      else $display("dual_line_call_controller_tb failed");
      $finish;
   end

endmodule
